FILE: sv/modbus_rtu_response_checker_macros.svh
// Assertion macros shared by the Modbus RTU response checker.
`ifndef MODBUS_RTU_RESPONSE_CHECKER_MACROS_SVH
`define MODBUS_RTU_RESPONSE_CHECKER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MRC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");

// Next-cycle implication, disabled during reset.
`define MRC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");

`endif

FILE: sv/mrc_pkg.sv
// Shared types, constants and the CRC byte update of the response checker.
package mrc_pkg;

   localparam int MAX_FRAME_BYTES_DEFAULT = 256;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   // Result queue: holds up to four results, at most two added per transfer.
   localparam int RESULT_DEPTH = 4;
   localparam int PTR_W = $clog2(RESULT_DEPTH);
   localparam int CNT_W = $clog2(RESULT_DEPTH + 1);

   localparam int RSP_DATA_W = 32;

   localparam logic KIND_WORD   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_CRC_BAD = 2'd1;
   localparam logic [1:0] STATUS_SHORT   = 2'd2;

   typedef struct packed {
      logic        kind;
      logic [6:0]  word_index;
      logic [15:0] word_value;
      logic [1:0]  frame_status;
      logic        last;
   } result_type;

   // Results produced by one accepted byte.
   typedef struct packed {
      logic        word_valid;
      logic        status_valid;
      logic [6:0]  word_index;
      logic [15:0] word_value;
      logic [1:0]  frame_status;
   } push_type;

   typedef struct packed {
      logic             space;
      logic [CNT_W-1:0] count;
   } fifo_status_type;

   // Reflected CRC-16 update over one byte, bit at a time.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

FILE: sv/mrc_frame.sv
// Frame tracker: CRC, byte position, data count and per-byte results.
module mrc_frame #(
   parameter int MAX_FRAME_BYTES = mrc_pkg::MAX_FRAME_BYTES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  logic [7:0]        rx_byte,
   input  logic              end_of_frame,
   output mrc_pkg::push_type push
);

   localparam int CW   = $clog2(MAX_FRAME_BYTES + 1);
   localparam int CMPW = (CW > 8) ? CW : 8;

   logic [15:0]   crc_ff, crc_in, crc_upd;
   logic [CW-1:0] seen_ff, seen_in;
   logic [7:0]    prev_ff, prev_in;
   logic [7:0]    older_ff, older_in;
   logic [7:0]    count_ff, count_in;

   logic          overlong;
   logic [CW-1:0] pos_minus4;
   logic [CMPW-1:0] idx_ext, half_count;
   logic          word_ok;
   logic [1:0]    status;

   assign overlong   = (seen_ff >= CW'(MAX_FRAME_BYTES));
   assign crc_upd    = (seen_ff >= CW'(2)) ? mrc_pkg::crc_byte(crc_ff, older_ff) : crc_ff;
   assign pos_minus4 = seen_ff - CW'(4);
   assign idx_ext    = CMPW'(pos_minus4 >> 1);
   assign half_count = CMPW'(count_ff >> 1);
   assign word_ok    = !overlong && (seen_ff >= CW'(4)) && !seen_ff[0]
                       && (idx_ext < half_count);

   always_comb begin
      priority if (overlong) begin
         status = mrc_pkg::STATUS_CRC_BAD;
      end else if (seen_ff < CW'(2)) begin
         status = mrc_pkg::STATUS_SHORT;
      end else if (crc_upd[7:0] == prev_ff && crc_upd[15:8] == rx_byte) begin
         status = mrc_pkg::STATUS_OK;
      end else begin
         status = mrc_pkg::STATUS_CRC_BAD;
      end
   end

   always_comb begin
      push.word_valid   = fire && word_ok;
      push.status_valid = fire && end_of_frame;
      push.word_index   = 7'(idx_ext);
      push.word_value   = {prev_ff, rx_byte};
      push.frame_status = status;
   end

   always_comb begin
      crc_in   = crc_ff;
      seen_in  = seen_ff;
      prev_in  = prev_ff;
      older_in = older_ff;
      count_in = count_ff;
      if (fire) begin
         if (end_of_frame) begin
            crc_in   = mrc_pkg::CRC_INIT;
            seen_in  = '0;
            prev_in  = '0;
            older_in = '0;
            count_in = '0;
         end else if (!overlong) begin
            crc_in   = crc_upd;
            seen_in  = seen_ff + CW'(1);
            prev_in  = rx_byte;
            older_in = prev_ff;
            if (seen_ff == CW'(2)) begin
               count_in = rx_byte;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff   <= mrc_pkg::CRC_INIT;
         seen_ff  <= '0;
         prev_ff  <= '0;
         older_ff <= '0;
         count_ff <= '0;
      end else begin
         crc_ff   <= crc_in;
         seen_ff  <= seen_in;
         prev_ff  <= prev_in;
         older_ff <= older_in;
         count_ff <= count_in;
      end
   end

endmodule

FILE: sv/mrc_result_fifo.sv
// Result queue: up to two writes and one read per cycle.
module mrc_result_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  mrc_pkg::push_type        push,
   input  logic                     pop,
   output mrc_pkg::result_type      head,
   output logic                     head_valid,
   output mrc_pkg::fifo_status_type status
);

   localparam int D  = mrc_pkg::RESULT_DEPTH;
   localparam int PW = mrc_pkg::PTR_W;
   localparam int CW = mrc_pkg::CNT_W;

   mrc_pkg::result_type entry_ff [D];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] count_ff, count_in;

   mrc_pkg::result_type word_res, status_res, first_res;
   logic [1:0]          npush;

   always_comb begin
      word_res.kind         = mrc_pkg::KIND_WORD;
      word_res.word_index   = push.word_index;
      word_res.word_value   = push.word_value;
      word_res.frame_status = mrc_pkg::STATUS_OK;
      word_res.last         = 1'b0;
      status_res.kind         = mrc_pkg::KIND_STATUS;
      status_res.word_index   = '0;
      status_res.word_value   = '0;
      status_res.frame_status = push.frame_status;
      status_res.last         = 1'b1;
      first_res = push.word_valid ? word_res : status_res;
      npush     = 2'(push.word_valid) + 2'(push.status_valid);
   end

   assign wr_in    = wr_ff + PW'(npush);
   assign rd_in    = rd_ff + PW'(pop);
   assign count_in = count_ff + CW'(npush) - CW'(pop);

   always_ff @(posedge clock) begin
      if (npush != 2'd0) begin
         entry_ff[wr_ff] <= first_res;
      end
      if (npush == 2'd2) begin
         entry_ff[wr_ff + PW'(1)] <= status_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   assign head         = entry_ff[rd_ff];
   assign head_valid   = (count_ff != '0);
   assign status.space = (count_ff <= CW'(D - 2));
   assign status.count = count_ff;

endmodule

FILE: sv/modbus_rtu_response_checker.sv
// Modbus RTU read-registers response checker: top level.
//
// Takes one response byte per transfer on req_ (tlast on the final byte) and
// returns register words and one frame status per frame on rsp_. Each byte is
// handled in the cycle it is accepted: CRC-16 update (poly 0xA001, seed 0xFFFF),
// byte position and data count live in the frame tracker, so a byte can be
// accepted every cycle while the queue has room. Results land in a four-deep
// queue and appear on rsp_ at the earliest in the cycle after the byte that made
// them, later when older results are still queued. A final byte that also closes a
// register word yields two results, word then status; req_tready stays high
// while at least two queue slots are free, so the sustained rate is one byte
// per cycle as long as the result side keeps up, and the queue depth sets how
// far the two sides may drift. Bytes past MAX_FRAME_BYTES are dropped and the
// frame then ends with a CRC mismatch status; a frame under three bytes ends
// with the too-short status.
module modbus_rtu_response_checker #(
   parameter int MAX_FRAME_BYTES = mrc_pkg::MAX_FRAME_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // Input bytes
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tlast,   // end_of_frame
   // Results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [mrc_pkg::RSP_DATA_W-1:0] rsp_tdata,
                                    // [6:0] word_index, [22:7] word_value,
                                    // [24:23] frame_status, [31:25] zero
   output logic        rsp_tuser,   // result_type: 0 word, 1 status
   output logic        rsp_tlast    // last_result
);

`include "modbus_rtu_response_checker_macros.svh"

   mrc_pkg::push_type        push;
   mrc_pkg::result_type      head;
   mrc_pkg::fifo_status_type fifo_status;
   logic                     req_fire;
   logic                     rsp_fire;

   // Accept a byte only when the queue can take a word and a status at once.
   assign req_tready = fifo_status.space;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;

   mrc_frame #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
   ) u_frame (
      .clock        (clock),
      .reset        (reset),
      .fire         (req_fire),
      .rx_byte      (req_tdata),
      .end_of_frame (req_tlast),
      .push         (push)
   );

   mrc_result_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (rsp_fire),
      .head       (head),
      .head_valid (rsp_tvalid),
      .status     (fifo_status)
   );

   // Pack the head result onto the stream.
   assign rsp_tdata = {7'd0, head.frame_status, head.word_value, head.word_index};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

   // Status results always close a frame; word results carry a zero status.
   `MRC_ASSERT_IMPLY(a_status_is_last, clock, reset,
      rsp_tvalid && rsp_tuser == mrc_pkg::KIND_STATUS, rsp_tlast)
   `MRC_ASSERT_IMPLY(a_word_status_zero, clock, reset,
      rsp_tvalid && rsp_tuser == mrc_pkg::KIND_WORD,
      rsp_tdata[24:23] == mrc_pkg::STATUS_OK && !rsp_tlast)
   // The queue never overfills.
   `MRC_ASSERT_IMPLY(a_fifo_bound, clock, reset,
      1'b1, fifo_status.count <= mrc_pkg::CNT_W'(mrc_pkg::RESULT_DEPTH))
   // A final byte always leaves a result behind.
   `MRC_ASSERT_NEXT(a_eof_result, clock, reset, req_fire && req_tlast, rsp_tvalid)

endmodule

FILE: test/tb.sv
// Self-checking testbench for the Modbus RTU read-registers response checker.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          FRAME_LIMIT  = mrc_pkg::MAX_FRAME_BYTES_DEFAULT;
   localparam logic [7:0]  READ_HOLDING = 8'h03;  // function code of a read response
   localparam int          RANDOM_BYTES = 1400;
   localparam int          HOLD_AT      = 400;    // byte count that starts the long stall
   localparam int          HOLD_CYCLES  = 200;
   localparam int          TAIL_CYCLES  = 16;

   // One byte on the request side.
   typedef struct {
      logic [7:0] data;
      logic       eof;
   } rx_item_type;

   // One result as the block should present it.
   typedef struct {
      logic        kind;
      logic [6:0]  word_index;
      logic [15:0] word_value;
      logic [1:0]  status;
      logic        last;
   } frame_result_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata  = 8'h00;  // [7:0] rx_byte
   logic                  req_tlast  = 1'b0;   // end_of_frame
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [mrc_pkg::RSP_DATA_W-1:0] rsp_tdata;  // [6:0] index, [22:7] value, [24:23] status
   logic                  rsp_tuser;           // result_type
   logic                  rsp_tlast;           // last_result

   rx_item_type      rx_pending[$];       // bytes still to be offered
   frame_result_type awaited_results[$];  // results predicted but not yet seen
   rx_item_type      next_item;
   frame_result_type seen_result;
   int            error_count    = 0;
   int            bytes_accepted = 0;
   int            send_gap       = 0;
   int            stall_left     = 0;
   int            hold_left      = 0;
   bit            hold_done      = 1'b0;

   // Frame tracking state of the predictor.
   logic [15:0] crc_run        = mrc_pkg::CRC_INIT;
   int          frame_pos      = 0;
   logic [7:0]  last_byte      = 8'h00;
   logic [7:0]  byte_before    = 8'h00;
   logic [7:0]  data_count     = 8'h00;

   always #4 clock = ~clock;

   modbus_rtu_response_checker #(
      .MAX_FRAME_BYTES(FRAME_LIMIT)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

   // Reflected CRC-16, one byte, LSB first.
   function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] acc;
      acc = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (acc[0]) begin
            acc = (acc >> 1) ^ mrc_pkg::CRC_POLY;
         end else begin
            acc = acc >> 1;
         end
      end
      return acc;
   endfunction

   function automatic void clear_frame();
      crc_run     = mrc_pkg::CRC_INIT;
      frame_pos   = 0;
      last_byte   = 8'h00;
      byte_before = 8'h00;
      data_count  = 8'h00;
   endfunction

   function automatic void expect_status(input logic [1:0] status);
      frame_result_type r;
      r.kind       = mrc_pkg::KIND_STATUS;
      r.word_index = '0;
      r.word_value = '0;
      r.status     = status;
      r.last       = 1'b1;
      awaited_results.push_back(r);
   endfunction

   // Predicts the results of one accepted byte and advances the frame state.
   // The CRC lags two bytes behind, so the last two bytes of a frame never
   // enter it; they are compared against it instead, low byte first.
   function automatic void track_response_byte(input logic [7:0] b, input logic eof);
      frame_result_type r;
      int            pos;
      int            idx;
      logic [7:0]    prev;
      pos  = frame_pos;
      prev = last_byte;
      // past the frame limit everything is dropped; eof still closes with a mismatch
      if (pos >= FRAME_LIMIT) begin
         if (eof) begin
            expect_status(mrc_pkg::STATUS_CRC_BAD);
            clear_frame();
         end
         return;
      end
      if (pos >= 2) crc_run = crc16_step(crc_run, byte_before);
      if (pos == 2) data_count = b;
      // words complete on even positions from 4 on; CRC bytes count if the
      // declared length runs past them
      if (pos >= 4 && pos % 2 == 0) begin
         idx = (pos - 4) / 2;
         if (idx < int'(data_count >> 1)) begin
            r.kind       = mrc_pkg::KIND_WORD;
            r.word_index = idx[6:0];
            r.word_value = {prev, b};
            r.status     = mrc_pkg::STATUS_OK;
            r.last       = 1'b0;
            awaited_results.push_back(r);
         end
      end
      byte_before = last_byte;
      last_byte   = b;
      frame_pos   = pos + 1;
      if (eof) begin
         if (pos + 1 < 3) begin
            expect_status(mrc_pkg::STATUS_SHORT);
         end else if (crc_run[7:0] == prev && crc_run[15:8] == b) begin
            expect_status(mrc_pkg::STATUS_OK);
         end else begin
            expect_status(mrc_pkg::STATUS_CRC_BAD);
         end
         clear_frame();
      end
   endfunction

   // Queues a frame, tlast on its final byte.
   function automatic void queue_frame(input logic [7:0] bytes[$]);
      rx_item_type it;
      foreach (bytes[i]) begin
         it.data = bytes[i];
         it.eof  = (i == bytes.size() - 1);
         rx_pending.push_back(it);
      end
   endfunction

   // Read response: address, function code, count, n_data random bytes, CRC.
   // A bad CRC flips a random nonzero set of its bits.
   function automatic void queue_read_response(input int n_data, input logic [7:0] count,
                                               input bit good_crc);
      logic [7:0]  bytes[$];
      logic [15:0] crc;
      bytes.push_back(8'($urandom_range(0, 255)));
      bytes.push_back(READ_HOLDING);
      bytes.push_back(count);
      repeat (n_data) bytes.push_back(8'($urandom_range(0, 255)));
      crc = mrc_pkg::CRC_INIT;
      foreach (bytes[i]) crc = crc16_step(crc, bytes[i]);
      if (!good_crc) crc = crc ^ 16'($urandom_range(1, 65535));
      bytes.push_back(crc[7:0]);
      bytes.push_back(crc[15:8]);
      queue_frame(bytes);
   endfunction

   function automatic void queue_noise(input int len);
      logic [7:0] bytes[$];
      repeat (len) bytes.push_back(8'($urandom_range(0, 255)));
      queue_frame(bytes);
   endfunction

   // Idling is off near the end and in one window in the middle.
   function automatic bit no_idling();
      return rx_pending.size() < 200 || (bytes_accepted >= 700 && bytes_accepted < 800);
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
         error_count++;
      end
   endfunction

   // Driver: offers the next queued byte once the current one is taken, with
   // random gaps between transfers. The predictor runs on each accepted byte.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            track_response_byte(req_tdata, req_tlast);
            bytes_accepted <= bytes_accepted + 1;
         end
         if (send_gap != 0) begin
            send_gap = send_gap - 1;
            req_tvalid <= 1'b0;
         end else if (rx_pending.size() != 0) begin
            next_item = rx_pending.pop_front();
            req_tdata  <= next_item.data;
            req_tlast  <= next_item.eof;
            req_tvalid <= 1'b1;
            if (!no_idling() && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 16);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Long back-pressure: once enough bytes are in, the receiver stops for a
   // while so the result queue fills and req_tready drops.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && bytes_accepted >= HOLD_AT) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Receiver: ready with random stall bursts.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left = stall_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (!no_idling() && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 16);
      end
   end

   // Monitor: each result transfer is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_results.size() == 0) begin
            $display("%0t ns: unexpected result: expected none, actual tuser %0b tdata 0x%0h",
                     $time, rsp_tuser, rsp_tdata);
            error_count++;
         end else begin
            seen_result = awaited_results.pop_front();
            check_field("result_type",  32'(seen_result.kind),       32'(rsp_tuser));
            check_field("word_index",   32'(seen_result.word_index), 32'(rsp_tdata[6:0]));
            check_field("word_value",   32'(seen_result.word_value), 32'(rsp_tdata[22:7]));
            check_field("frame_status", 32'(seen_result.status),     32'(rsp_tdata[24:23]));
            check_field("tdata_pad",    32'(0), 32'(rsp_tdata[mrc_pkg::RSP_DATA_W-1:25]));
            check_field("last_result",  32'(seen_result.last),       32'(rsp_tlast));
         end
      end
   end

   initial begin
      int         pick;
      logic [7:0] hdr[$];
      bit         max_done;
      bit         over_done;

      // Directed frames.
      hdr = '{8'hFF};                             // lone byte: too short
      queue_frame(hdr);
      hdr = '{8'h00, 8'hFF};                      // two bytes: too short
      queue_frame(hdr);
      hdr = '{8'h01, READ_HOLDING, 8'h00};        // three bytes, CRC cannot match
      queue_frame(hdr);
      queue_read_response(2, 8'd2, 1'b1);         // one word, good CRC
      queue_read_response(3, 8'd3, 1'b1);         // odd count, spare byte dropped
      queue_read_response(2, 8'd8, 1'b0);         // count past the end, word on the last
                                                  // byte, then CRC mismatch

      // Random frames, mostly well formed, with one full-size and one
      // overlong frame mixed in.
      max_done  = 1'b0;
      over_done = 1'b0;
      while (rx_pending.size() < RANDOM_BYTES) begin
         pick = $urandom_range(0, 99);
         if (!max_done && rx_pending.size() > 300) begin
            queue_read_response(FRAME_LIMIT - 5, 8'hFF, 1'b1);
            max_done = 1'b1;
         end else if (!over_done && rx_pending.size() > 800) begin
            queue_read_response(FRAME_LIMIT - 4 + $urandom_range(0, 6),
                                8'($urandom_range(0, 255)), $urandom_range(0, 1));
            over_done = 1'b1;
         end else if (pick < 70) begin
            pick = $urandom_range(0, 8);
            queue_read_response(2 * pick, 8'(2 * pick), 1'b1);
         end else if (pick < 80) begin
            pick = $urandom_range(0, 8);
            queue_read_response(2 * pick, 8'(2 * pick), 1'b0);
         end else if (pick < 88) begin
            queue_read_response($urandom_range(0, 12), 8'($urandom_range(0, 255)),
                                $urandom_range(0, 1));
         end else if (pick < 94) begin
            queue_noise($urandom_range(1, 2));
         end else begin
            queue_noise($urandom_range(3, 12));
         end
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Drain: everything sent, everything received, then a short tail.
      @(negedge clock);
      while (rx_pending.size() != 0 || req_tvalid || awaited_results.size() != 0) begin
         @(negedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (awaited_results.size() != 0) begin
         $display("%0t ns: %0d results never arrived", $time, awaited_results.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
